### design/lru_key_value_cache_defines.svh
// assertion macros used by the cache datapath
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// implication checked on every edge outside reset
`define LKVC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition that must hold on every edge outside reset
`define LKVC_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

`endif

### design/lkvc_pkg.sv
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int AGE_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;
    localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

    // request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // register indexes
    localparam int REG_CAPACITY = 0;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } lkvc_cmd_t;

    typedef struct packed {
        logic out_free;
    } lkvc_sts_t;

endpackage

### design/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lkvc_pkg::lkvc_sts_t sts,
    output lkvc_pkg::lkvc_cmd_t cmd
);
    import lkvc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.commit  = (state_reg == ST_UPDATE) && sts.out_free;
        s_tready    = (state_reg == ST_IDLE) || cmd.commit;
        cmd.capture = s_tvalid && s_tready;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (cmd.commit) state_next = cmd.capture ? ST_LOOKUP : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/lkvc_datapath.sv
`include "lru_key_value_cache_defines.svh"

module lkvc_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lkvc_pkg::lkvc_cmd_t         cmd,
    output lkvc_pkg::lkvc_sts_t         sts,
    input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
    input  logic [63:0]                 s_tdata,   // key, value
    input  logic                        s_tuser,   // op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // read_value
    output logic                        m_tuser    // hit
);
    import lkvc_pkg::*;

    // request capture
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] value_reg;

    // entry store
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [AGE_W-1:0]       age_reg [MAX_ENTRIES];
    logic [AGE_W-1:0]       age_next [MAX_ENTRIES];
    logic [KEY_W-1:0]       key_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]      data_mem [MAX_ENTRIES];
    logic [CNT_W-1:0]       occ_reg, occ_next;

    // lookup results
    logic [MAX_ENTRIES-1:0] match_vec_reg, victim_vec_reg, free_vec_reg;
    logic                   fill_reg;
    logic [MAX_ENTRIES-1:0] match_c, victim_c, free_c;
    logic                   fill_c;
    logic                   free_seen;
    logic [CMP_W-1:0]       cap_w, eff_cap;
    logic [AGE_W-1:0]       oldest_age;

    // update
    logic                   hit, is_put, change, evict;
    logic [MAX_ENTRIES-1:0] tgt;
    logic [AGE_W-1:0]       old_age;
    logic [DATA_W-1:0]      hit_data;
    logic [MAX_ENTRIES-1:0] bump;
    logic [DATA_W-1:0]      result;

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_data_reg;

    always_comb begin
        cap_w = CMP_W'(capacity);
        if (cap_w == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_w > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_w;
        end
        fill_c     = CMP_W'(occ_reg) < eff_cap;
        oldest_age = AGE_W'(occ_reg - CNT_W'(1));
        free_seen  = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_c[i]  = valid_reg[i] && (key_mem[i] == key_reg);
            victim_c[i] = valid_reg[i] && (age_reg[i] == oldest_age);
            free_c[i]   = !valid_reg[i] && !free_seen;
            if (!valid_reg[i]) free_seen = 1'b1;
        end
    end

    // commit side: on a hit or a put, one target entry moves to most recent
    always_comb begin
        hit    = |match_vec_reg;
        is_put = (op_reg == OP_PUT);
        change = hit || is_put;
        // put miss replacing the least recent entry, being committed
        evict  = cmd.commit && is_put && !hit && !fill_reg;
        if (hit) begin
            tgt = match_vec_reg;
        end else if (fill_reg) begin
            tgt = free_vec_reg;
        end else begin
            tgt = victim_vec_reg;
        end
        old_age  = '0;
        hit_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (tgt[i]) old_age = old_age | age_reg[i];
            if (match_vec_reg[i]) hit_data = hit_data | data_mem[i];
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            bump[i] = valid_reg[i] && !tgt[i]
                      && ((!hit && fill_reg) || (age_reg[i] < old_age));
        end
        if (is_put) begin
            result = PUT_VALUE;
        end else if (hit) begin
            result = hit_data;
        end else begin
            result = MISS_VALUE;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            age_next[i] = age_reg[i];
            if (cmd.commit && change) begin
                if (tgt[i]) begin
                    age_next[i]   = '0;
                    valid_next[i] = 1'b1;
                end else if (bump[i]) begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
        if (cmd.commit && is_put && !hit && fill_reg) occ_next = occ_reg + CNT_W'(1);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            value_reg <= s_tdata[KEY_W+DATA_W-1:KEY_W];
        end
        if (cmd.lookup) begin
            match_vec_reg  <= match_c;
            victim_vec_reg <= victim_c;
            free_vec_reg   <= free_c;
            fill_reg       <= fill_c;
        end
        if (cmd.commit) begin
            out_hit_reg  <= hit;
            out_data_reg <= result;
            if (is_put) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (tgt[i]) begin
                        data_mem[i] <= value_reg;
                        if (!hit) key_mem[i] <= key_reg;
                    end
                end
            end
        end
    end

    `LKVC_ASSERT_IMPL(a_unique_match, cmd.commit, $onehot0(match_vec_reg), "duplicate key match")
    `LKVC_ASSERT_IMPL(a_victim_found, evict, $onehot(victim_vec_reg), "no single eviction victim")
    `LKVC_ASSERT_ALWAYS(a_occ_bound, occ_reg <= CNT_W'(MAX_ENTRIES), "occupancy above entry count")
    `LKVC_ASSERT_IMPL(a_result_loaded, cmd.commit, ##1 m_tvalid, "committed result not presented")

endmodule

### design/lru_key_value_cache.sv
// Fully associative key/value cache of 16 entries with least-recently-used
// replacement. Each request on the s_ stream is a get (s_tuser = 0) or a put
// (s_tuser = 1) of a 32-bit key and value, and gives exactly one result on the
// m_ stream: m_tuser is the hit flag and m_tdata the stored value on a get hit,
// all ones (-1) on a get miss and zero on any put. A put that misses fills a
// free entry while fewer than capacity_in_use entries are held, otherwise it
// replaces the least recent entry; lowering the capacity drops nothing at once.
// A request first goes through a tag compare of the key against every stored
// tag in parallel, which registers the match, victim and free-slot vectors,
// then through an update that rewrites the recency ranks and the target entry
// and is held while the result register is full. The next request is taken
// as the previous one commits its update. capacity_in_use sits at APB byte
// address 0 (reset 16; zero acts as one, values above 16 as 16); the user must
// write it only while the cache is idle, as the block does not enforce this.
module lru_key_value_cache (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic        s_tuser,   // op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value
    output logic        m_tuser,   // hit
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lkvc_pkg::*;

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             sel_cap;
    lkvc_cmd_t        cmd;
    lkvc_sts_t        sts;

    // register index from the word address
    assign sel_cap = (paddr[2] == REG_CAPACITY[0]);
    assign pready  = 1'b1;
    assign prdata  = sel_cap ? {{(32 - CAP_W){1'b0}}, cap_reg} : '0;

    always_comb begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && sel_cap) cap_next = pwdata[CAP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    // sequencing: idle, tag compare, update
    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entry store, recency ranks and result register
    lkvc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .capacity (cap_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### bench/lru_key_value_cache_test.sv
module lru_key_value_cache_test;
    import lkvc_pkg::*;

    localparam int CLK_PERIOD  = 4;
    localparam int RESET_TICKS = 7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int POOL_SIZE   = 24;
    localparam int SETTLE      = 6;

    // one expected reply per request
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } cache_reply_t;

    // mirror of the cache contents plus the queue of replies still owed
    class lru_scoreboard;
        logic              slot_used [MAX_ENTRIES];
        logic [KEY_W-1:0]  slot_key  [MAX_ENTRIES];
        logic [DATA_W-1:0] slot_data [MAX_ENTRIES];
        logic [AGE_W-1:0]  slot_rank [MAX_ENTRIES];
        int unsigned       fill_count;
        logic [CAP_W-1:0]  capacity;
        cache_reply_t      awaited [$];
        int                errors;

        function new();
            capacity   = CAP_RESET;
            fill_count = 0;
            errors     = 0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_rank[i] = '0;
            end
        endfunction

        function void set_capacity(logic [31:0] v);
            capacity = v[CAP_W-1:0];
        endfunction

        // zero acts as one, anything past the table size saturates
        function int unsigned usable_slots();
            if (capacity == 0)
                return 1;
            if (capacity > MAX_ENTRIES)
                return MAX_ENTRIES;
            return capacity;
        endfunction

        // entries more recent than slot s move back by one
        function void make_newest(int s);
            logic [AGE_W-1:0] old_rank;
            old_rank = slot_rank[s];
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (i != s && slot_used[i] && slot_rank[i] < old_rank)
                    slot_rank[i] = slot_rank[i] + 1'b1;
            slot_rank[s] = '0;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key,
                                   logic [DATA_W-1:0] value);
            int           found;
            int           slot;
            int           victim;
            cache_reply_t r;
            found  = -1;
            slot   = -1;
            victim = -1;
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (found < 0 && slot_used[i] && slot_key[i] == key)
                    found = i;
            if (found >= 0) begin
                r.hit = 1'b1;
                if (op == OP_GET) begin
                    r.read_value = slot_data[found];
                end else begin
                    slot_data[found] = value;
                    r.read_value     = PUT_VALUE;
                end
                make_newest(found);
            end else if (op == OP_GET) begin
                r.hit        = 1'b0;
                r.read_value = MISS_VALUE;
            end else begin
                r.hit        = 1'b0;
                r.read_value = PUT_VALUE;
                if (fill_count < usable_slots())
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (slot < 0 && !slot_used[i])
                            slot = i;
                if (slot >= 0) begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (slot_used[i])
                            slot_rank[i] = slot_rank[i] + 1'b1;
                    slot_used[slot] = 1'b1;
                    slot_key[slot]  = key;
                    slot_data[slot] = value;
                    slot_rank[slot] = '0;
                    fill_count++;
                end else begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                            victim = i;
                    if (victim >= 0) begin
                        slot_key[victim]  = key;
                        slot_data[victim] = value;
                        make_newest(victim);
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic hit, logic [DATA_W-1:0] read_value);
            cache_reply_t e;
            if (awaited.size() == 0) begin
                $display("%0t: reply with nothing owed, hit %0b value %08h",
                         $time, hit, read_value);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
            if (read_value !== e.read_value) begin
                $display("%0t: read_value expected %08h actual %08h",
                         $time, e.read_value, read_value);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] key, [63:32] value
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_value
    logic        m_tuser;   // hit
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lru_key_value_cache dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lru_scoreboard    sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               cycle_count;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               pool_span;
    int               phase_cap   [PHASES];
    int               phase_idle  [PHASES];
    int               phase_stall [PHASES];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random back-pressure, changed on the falling edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // every reply taken is compared against the oldest owed one
    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);

    // one request on the input stream; entered and left at a falling edge,
    // with tvalid left high so a back-to-back request needs no second drive
    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {value, key};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, key, value);
        @(negedge aclk);
    endtask

    // hold the input stream until every reply is back, then let it settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (sb.awaited.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic apb_access(input logic write, input int index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= 3'(index * 4);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write the capacity, mirror it, and read it back
    task automatic set_capacity(input logic [31:0] value);
        logic [31:0] readback;
        apb_access(1'b1, REG_CAPACITY, value, readback);
        sb.set_capacity(value);
        apb_access(1'b0, REG_CAPACITY, '0, readback);
        if (readback !== 32'(value[CAP_W-1:0])) begin
            $display("%0t: capacity readback expected %08h actual %08h",
                     $time, 32'(value[CAP_W-1:0]), readback);
            sb.errors++;
        end
    endtask

    // mostly keys from a small pool so hits and evictions both happen
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(pool_span - 1)];
        return $urandom;
    endfunction

    task automatic run_directed();
        // empty cache, lone entry, extremes of key and value
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // hit on the newest entry, then older ones
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        // put that hits overwrites the data
        send_request(OP_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
        drain(SETTLE);
        // capacity zero behaves as one and sits below the occupancy
        set_capacity(32'd0);
        send_request(OP_PUT, 32'h0000_0005, 32'h0000_0055);
        send_request(OP_PUT, 32'h0000_0006, 32'h0000_0066);
        send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0006, 32'h0000_0000);
        send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
        drain(SETTLE);
    endtask

    initial begin
        int unsigned eff;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_GET;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sb             = new();

        // capacity per phase, with idle and stall rates per phase
        phase_cap   = '{16, 1, 31, 4, 0, 9, 2, 16};
        phase_idle  = '{0, 49, 0, 36, 0, 49, 0, 36};
        phase_stall = '{0, 0, 49, 36, 0, 0, 49, 36};

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (RESET_TICKS) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            set_capacity(32'(phase_cap[p]));
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            // pool a little wider than the capacity so misses still evict
            eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > MAX_ENTRIES) ?
                  MAX_ENTRIES : phase_cap[p];
            pool_span = (eff + 6 > POOL_SIZE) ? POOL_SIZE : eff + 6;
            for (int i = 0; i < 6; i++)
                key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until the cache has caught up
                if (n == PHASE_ITEMS / 2)
                    drain(0);
                send_request(logic'($urandom_range(1)), pick_key(), $urandom);
            end
            drain(SETTLE);
        end

        // all requests taken; wait out any reply still in flight
        drain(2 * SETTLE);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
